[hdl/zsav_pkg.sv]
package zsav_pkg;

    localparam logic [31:0] CRC_POLY        = 32'hedb88320;
    localparam logic [31:0] SIG_LOCAL       = 32'h04034b50;
    localparam logic [31:0] SIG_CENTRAL     = 32'h02014b50;
    localparam logic [31:0] SIG_END         = 32'h06054b50;
    localparam logic [15:0] FLAG_DESCRIPTOR = 16'h0008;
    localparam logic [16:0] MAX_ENTRIES     = 17'h0ffff;
    localparam logic [47:0] CAP_RESET       = 48'hffffffffffff;

    typedef enum logic [3:0]
    {
        ERR_NONE        = 4'd0,
        ERR_TRUNCATED   = 4'd1,
        ERR_SIGNATURE   = 4'd2,
        ERR_UNSUPPORTED = 4'd3,
        ERR_UNSAFE_NAME = 4'd4,
        ERR_TOO_MANY    = 4'd5,
        ERR_TOO_LARGE   = 4'd6,
        ERR_CRC         = 4'd7,
        ERR_BAD_TIME    = 4'd8
    } err_t;

    typedef enum logic [5:0]
    {
        PH_SIG   = 6'b000001,
        PH_HDR   = 6'b000010,
        PH_NAME  = 6'b000100,
        PH_EXTRA = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    // Segment kind of the name checker.
    localparam logic [1:0] SEG_EMPTY = 2'd0;
    localparam logic [1:0] SEG_OTHER = 2'd3;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic time_valid(input logic [15:0] tm, input logic [15:0] dt);
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] sec2;
        month  = dt[8:5];
        day    = dt[4:0];
        hour   = tm[15:11];
        minute = tm[10:5];
        sec2   = tm[4:0];
        return (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) &&
               (hour <= 5'd23) && (minute <= 6'd59) && (sec2 <= 5'd29);
    endfunction

endpackage

[hdl/zip_stored_archive_validator_core.sv]
// ZIP stored-archive validator.
// The in channel carries one archive byte per request (data_byte, stream_last)
// under in_valid / in_stall. The out channel carries one verdict per archive
// (archive_ok, error_code, entries_seen, bytes_seen, times_uniform) under
// out_valid / out_stall. The cfg channel (cfg_valid / cfg_ready) writes the
// 48-bit total-size cap; write it only while the block is idle.
// Throughput is one byte per cycle unless a stalled verdict holds the input: each byte's CRC step, header capture and
// checks are done by the logic between the input register and the result
// register. A verdict passes from the byte in the input register into the result register.
// Bytes after a verdict are dropped until stream_last, after which the parser
// starts fresh on the next archive.
// Reset clears the parser and sets the cap to all ones. When the receiver
// stalls, the held verdict stays put, and in_stall is raised while a request
// waits in the input register until the verdict is taken.
module zip_stored_archive_validator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        archive_ok,
    output logic [3:0]  error_code,
    output logic [15:0] entries_seen,
    output logic [47:0] bytes_seen,
    output logic        times_uniform,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [47:0] cfg_data
);
    import zsav_pkg::*;

    logic [47:0] cap_reg;

    logic        iv_reg;
    logic [7:0]  ib_reg;
    logic        il_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] sig_reg, sig_next;
    logic [7:0]  hdr_reg [26];
    logic [31:0] crc_reg, crc_next;
    logic [16:0] ent_reg, ent_next;
    logic [47:0] tot_reg, tot_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        uni_reg, uni_next;
    logic [2:0]  nchk_reg, nchk_next;

    logic        ov_reg;
    logic        ok_reg;
    logic [3:0]  code_reg;
    logic [15:0] ents_reg;
    logic [47:0] bytes_reg;
    logic        uni_out_reg;

    logic        emit;
    err_t        code;
    logic        proc;
    logic        adv;

    // The extra length's high byte is the last header byte, so with an empty
    // name it is still in the input register when it is needed.
    logic [7:0] xlen_hi;
    assign xlen_hi = (phase_reg == PH_HDR) ? ib_reg : hdr_reg[25];

    // Header byte fields, assembled from the captured bytes (little endian).
    logic [15:0] h_flags, h_method, h_time, h_date, h_nlen, h_xlen;
    logic [31:0] h_crc, h_csize, h_usize;
    assign h_flags  = {hdr_reg[3], hdr_reg[2]};
    assign h_method = {hdr_reg[5], hdr_reg[4]};
    assign h_time   = {hdr_reg[7], hdr_reg[6]};
    assign h_date   = {hdr_reg[9], hdr_reg[8]};
    assign h_crc    = {hdr_reg[13], hdr_reg[12], hdr_reg[11], hdr_reg[10]};
    assign h_csize  = {hdr_reg[17], hdr_reg[16], hdr_reg[15], hdr_reg[14]};
    assign h_usize  = {hdr_reg[21], hdr_reg[20], hdr_reg[19], hdr_reg[18]};
    assign h_nlen   = {hdr_reg[23], hdr_reg[22]};
    assign h_xlen   = {xlen_hi, hdr_reg[24]};

    // The output slot is free, or will be, when out_valid drops or is taken.
    assign adv      = !ov_reg || !out_stall;
    assign proc     = iv_reg && adv;
    assign in_stall = iv_reg && !adv;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [2:0]  nc;
        logic [1:0]  kind;
        logic        bad;
        logic [31:0] crc_fin;
        logic [48:0] sum;
        logic        hdr_end;
        logic        data_end;
        logic [31:0] stamp;
        logic [7:0]  b;

        phase_next = phase_reg;
        count_next = count_reg;
        sig_next   = sig_reg;
        crc_next   = crc_reg;
        ent_next   = ent_reg;
        tot_next   = tot_reg;
        stamp_next = stamp_reg;
        uni_next   = uni_reg;
        nchk_next  = nchk_reg;
        emit       = 1'b0;
        code       = ERR_NONE;
        hdr_end    = 1'b0;
        data_end   = 1'b0;
        nc         = nchk_reg;
        crc_fin    = crc_reg;
        b          = ib_reg;
        stamp      = {h_date, h_time};
        sum        = {1'b0, tot_reg} + {17'd0, h_usize};
        kind       = nc[1:0];
        bad        = nc[2];

        unique case (phase_reg)
            PH_SIG:
            begin
                sig_next   = {b, sig_reg[31:8]};
                count_next = count_reg + 32'd1;
                if (count_reg[1:0] == 2'd3)
                begin
                    count_next = 32'd0;
                    if (sig_next == SIG_CENTRAL || sig_next == SIG_END)
                    begin
                        emit = 1'b1;
                    end
                    else if (sig_next != SIG_LOCAL)
                    begin
                        emit = 1'b1;
                        code = ERR_SIGNATURE;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                    end
                end
            end
            PH_HDR:
            begin
                count_next = count_reg + 32'd1;
                if (count_reg == 32'd25)
                begin
                    phase_next = PH_NAME;
                    count_next = {16'd0, h_nlen};
                    nchk_next  = 3'd0;
                    if (h_nlen == 16'd0)
                    begin
                        nc = 3'd0;
                        hdr_end = 1'b1;
                    end
                end
            end
            PH_NAME:
            begin
                if (b == 8'h5c || b == 8'h3a)
                begin
                    bad  = 1'b1;
                    kind = SEG_OTHER;
                end
                else if (b == 8'h2f)
                begin
                    if (kind != SEG_OTHER)
                    begin
                        bad = 1'b1;
                    end
                    kind = SEG_EMPTY;
                end
                else if (b == 8'h2e)
                begin
                    kind = (kind == SEG_OTHER) ? SEG_OTHER : kind + 2'd1;
                end
                else
                begin
                    kind = SEG_OTHER;
                end
                nc         = {bad, kind};
                nchk_next  = nc;
                count_next = count_reg - 32'd1;
                if (count_reg == 32'd1)
                begin
                    hdr_end = 1'b1;
                end
            end
            PH_EXTRA:
            begin
                count_next = count_reg - 32'd1;
                if (count_reg == 32'd1)
                begin
                    hdr_end = 1'b1;
                end
            end
            PH_DATA:
            begin
                crc_next   = crc_byte(crc_reg, b);
                crc_fin    = crc_next;
                count_next = count_reg - 32'd1;
                if (count_reg == 32'd1)
                begin
                    data_end = 1'b1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // End of name (or header with an empty name): finish the name check,
        // then either enter the extra field or run the entry checks.
        if (hdr_end && phase_reg != PH_EXTRA)
        begin
            if (nc[1:0] != SEG_OTHER)
            begin
                nc[2] = 1'b1;
            end
            nchk_next = nc;
            if (h_xlen != 16'd0)
            begin
                phase_next = PH_EXTRA;
                count_next = {16'd0, h_xlen};
                hdr_end    = 1'b0;
            end
        end

        if (hdr_end)
        begin
            if (h_flags[3] || h_method != 16'd0 || h_csize != h_usize)
            begin
                emit = 1'b1;
                code = ERR_UNSUPPORTED;
            end
            else if (nc[2])
            begin
                emit = 1'b1;
                code = ERR_UNSAFE_NAME;
            end
            else if (ent_reg >= MAX_ENTRIES)
            begin
                emit = 1'b1;
                code = ERR_TOO_MANY;
            end
            else if (sum > {1'b0, cap_reg})
            begin
                emit = 1'b1;
                code = ERR_TOO_LARGE;
            end
            else
            begin
                tot_next = sum[47:0];
                if (ent_reg == 17'd0)
                begin
                    stamp_next = stamp;
                end
                else if (stamp != stamp_reg)
                begin
                    uni_next = 1'b0;
                end
                ent_next   = ent_reg + 17'd1;
                phase_next = PH_DATA;
                count_next = h_csize;
                crc_next   = 32'hffffffff;
                crc_fin    = 32'hffffffff;
                if (h_csize == 32'd0)
                begin
                    data_end = 1'b1;
                end
            end
        end

        if (data_end)
        begin
            if (~crc_fin != h_crc)
            begin
                emit = 1'b1;
                code = ERR_CRC;
            end
            else if (!time_valid(h_time, h_date))
            begin
                emit = 1'b1;
                code = ERR_BAD_TIME;
            end
            else
            begin
                phase_next = PH_SIG;
                count_next = 32'd0;
            end
        end

        if (!emit && il_reg && phase_reg != PH_DONE)
        begin
            emit = 1'b1;
            code = ERR_TRUNCATED;
        end
        if (emit)
        begin
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            iv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            ib_reg <= data_byte;
            il_reg <= stream_last;
        end
        if (proc && phase_reg == PH_HDR)
        begin
            hdr_reg[count_reg[4:0]] <= ib_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            count_reg <= 32'd0;
            sig_reg   <= 32'd0;
            crc_reg   <= 32'hffffffff;
            ent_reg   <= 17'd0;
            tot_reg   <= 48'd0;
            uni_reg   <= 1'b1;
            nchk_reg  <= 3'd0;
        end
        else if (proc)
        begin
            if (il_reg)
            begin
                phase_reg <= PH_SIG;
                count_reg <= 32'd0;
                sig_reg   <= 32'd0;
                crc_reg   <= 32'hffffffff;
                ent_reg   <= 17'd0;
                tot_reg   <= 48'd0;
                uni_reg   <= 1'b1;
                nchk_reg  <= 3'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                sig_reg   <= sig_next;
                crc_reg   <= crc_next;
                ent_reg   <= ent_next;
                tot_reg   <= tot_next;
                uni_reg   <= uni_next;
                nchk_reg  <= nchk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            stamp_reg <= stamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= proc && emit;
        end
    end

    // An entry admitted by this very byte already counts in the verdict.
    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            ok_reg      <= (code == ERR_NONE);
            code_reg    <= code;
            ents_reg    <= ent_next[15:0];
            bytes_reg   <= tot_next;
            uni_out_reg <= (code == ERR_NONE) && (ent_next != 17'd0) && uni_next;
        end
    end

    assign out_valid     = ov_reg;
    assign archive_ok    = ok_reg;
    assign error_code    = code_reg;
    assign entries_seen  = ents_reg;
    assign bytes_seen    = bytes_reg;
    assign times_uniform = uni_out_reg;

endmodule

[test/zip_stored_archive_validator_checker.sv]
`timescale 1ns / 100ps

module zip_stored_archive_validator_checker
    import zsav_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        archive_ok,
    input  logic [3:0]  error_code,
    input  logic [15:0] entries_seen,
    input  logic [47:0] bytes_seen,
    input  logic        times_uniform,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [47:0] cfg_data,
    output int          fail_count,
    output int          verdicts_pending,
    output int          verdicts_checked,
    output int          clean_verdicts
);

    typedef struct packed
    {
        logic        ok;
        logic [3:0]  code;
        logic [15:0] entries;
        logic [47:0] total;
        logic        uniform;
    } verdict_t;

    localparam int CLEAN_END = 100;

    verdict_t    verdict_q[$];
    logic [47:0] size_cap;
    phase_t      phase;
    logic [31:0] count;
    logic [31:0] sig_shift;
    logic [7:0]  hdr [0:25];
    logic [31:0] crc;
    logic [16:0] entry_cnt;
    logic [47:0] byte_sum;
    logic [31:0] stamp0;
    logic        uniform;
    logic [1:0]  seg_kind;
    logic        name_bad;

    assign verdicts_pending = verdict_q.size();

    function automatic logic [15:0] h16(input int i);
        return {hdr[i + 1], hdr[i]};
    endfunction

    function automatic logic [31:0] h32(input int i);
        return {h16(i + 2), h16(i)};
    endfunction

    function automatic logic stamp_ok(input logic [15:0] tm, input logic [15:0] dt);
        return dt[8:5] >= 1 && dt[8:5] <= 12 && dt[4:0] >= 1 &&
               tm[15:11] <= 23 && tm[10:5] <= 59 && tm[4:0] <= 29;
    endfunction

    task automatic clear_archive();
        phase     = PH_SIG;
        count     = 32'd0;
        sig_shift = 32'd0;
        crc       = 32'hffffffff;
        entry_cnt = 17'd0;
        byte_sum  = 48'd0;
        stamp0    = 32'd0;
        uniform   = 1'b1;
        seg_kind  = SEG_EMPTY;
        name_bad  = 1'b0;
    endtask

    function automatic int finish_data();
        if (~crc != h32(10))
            return ERR_CRC;
        if (!stamp_ok(h16(6), h16(8)))
            return ERR_BAD_TIME;
        phase = PH_SIG;
        count = 32'd0;
        return 0;
    endfunction

    function automatic int admit_entry();
        logic [31:0] csize;
        logic [31:0] usize;
        logic [31:0] stamp;
        logic [48:0] sum;
        csize = h32(14);
        usize = h32(18);
        stamp = {h16(8), h16(6)};
        sum   = {1'b0, byte_sum} + {17'd0, usize};
        if ((h16(2) & FLAG_DESCRIPTOR) != 0 || h16(4) != 0 || csize != usize)
            return ERR_UNSUPPORTED;
        if (name_bad)
            return ERR_UNSAFE_NAME;
        if (entry_cnt >= MAX_ENTRIES)
            return ERR_TOO_MANY;
        if (sum > {1'b0, size_cap})
            return ERR_TOO_LARGE;
        byte_sum = sum[47:0];
        if (entry_cnt == 0)
            stamp0 = stamp;
        else if (stamp != stamp0)
            uniform = 1'b0;
        entry_cnt++;
        phase = PH_DATA;
        count = csize;
        crc   = 32'hffffffff;
        if (csize == 0)
            return finish_data();
        return 0;
    endfunction

    function automatic int finish_name();
        if (seg_kind != SEG_OTHER)
            name_bad = 1'b1;
        if (h16(24) != 0)
        begin
            phase = PH_EXTRA;
            count = {16'd0, h16(24)};
            return 0;
        end
        return admit_entry();
    endfunction

    function automatic int parse_byte(input logic [7:0] b);
        case (phase)
            PH_SIG:
            begin
                sig_shift = {b, sig_shift[31:8]};
                count++;
                if (count < 4)
                    return 0;
                count = 32'd0;
                if (sig_shift == SIG_CENTRAL || sig_shift == SIG_END)
                    return CLEAN_END;
                if (sig_shift != SIG_LOCAL)
                    return ERR_SIGNATURE;
                phase = PH_HDR;
                return 0;
            end
            PH_HDR:
            begin
                hdr[count] = b;
                count++;
                if (count < 26)
                    return 0;
                phase    = PH_NAME;
                count    = {16'd0, h16(22)};
                seg_kind = SEG_EMPTY;
                name_bad = 1'b0;
                if (count == 0)
                    return finish_name();
                return 0;
            end
            PH_NAME:
            begin
                if (b == "\\" || b == ":")
                begin
                    name_bad = 1'b1;
                    seg_kind = SEG_OTHER;
                end
                else if (b == "/")
                begin
                    if (seg_kind != SEG_OTHER)
                        name_bad = 1'b1;
                    seg_kind = SEG_EMPTY;
                end
                else if (b == ".")
                    seg_kind = (seg_kind == SEG_OTHER) ? SEG_OTHER : seg_kind + 2'd1;
                else
                    seg_kind = SEG_OTHER;
                count--;
                return (count == 0) ? finish_name() : 0;
            end
            PH_EXTRA:
            begin
                count--;
                return (count == 0) ? admit_entry() : 0;
            end
            PH_DATA:
            begin
                crc = crc ^ {24'd0, b};
                for (int k = 0; k < 8; k++)
                    crc = (crc >> 1) ^ (32'hedb88320 & {32{crc[0]}});
                count--;
                return (count == 0) ? finish_data() : 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic add_verdict(input int code);
        verdict_t v;
        v.ok      = (code == 0);
        v.code    = code[3:0];
        v.entries = entry_cnt[15:0];
        v.total   = byte_sum;
        v.uniform = (code == 0) && entry_cnt > 0 && uniform;
        verdict_q = {verdict_q, v};
        phase = PH_DONE;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        int r;
        if (phase != PH_DONE)
        begin
            r = parse_byte(b);
            if (r == CLEAN_END)
                add_verdict(ERR_NONE);
            else if (r != 0)
                add_verdict(r);
            else if (last)
                add_verdict(ERR_TRUNCATED);
        end
        if (last)
            clear_archive();
    endtask

    task automatic check_verdict();
        verdict_t e;
        verdicts_checked++;
        if (verdict_q.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected verdict ok=%0d code=%0d", $time, archive_ok, error_code);
        end
        else
        begin
            e = verdict_q.pop_front();
            if (archive_ok !== e.ok)
            begin
                fail_count++;
                $display("%0t: archive_ok expected %0d actual %0d", $time, e.ok, archive_ok);
            end
            if (error_code !== e.code)
            begin
                fail_count++;
                $display("%0t: error_code expected %0d actual %0d", $time, e.code,
                         error_code);
            end
            if (entries_seen !== e.entries)
            begin
                fail_count++;
                $display("%0t: entries_seen expected %0d actual %0d", $time, e.entries,
                         entries_seen);
            end
            if (bytes_seen !== e.total)
            begin
                fail_count++;
                $display("%0t: bytes_seen expected %0d actual %0d", $time, e.total,
                         bytes_seen);
            end
            if (times_uniform !== e.uniform)
            begin
                fail_count++;
                $display("%0t: times_uniform expected %0d actual %0d", $time, e.uniform,
                         times_uniform);
            end
            if (e.ok)
                clean_verdicts++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cap = CAP_RESET;
            clear_archive();
            verdict_q.delete();
            fail_count       = 0;
            verdicts_checked = 0;
            clean_verdicts   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_cap = cfg_data;
            if (in_valid && !in_stall)
                take_byte(data_byte, stream_last);
            if (out_valid && !out_stall)
                check_verdict();
        end
    end

endmodule

[test/tb_zip_stored_archive_validator_core.sv]
`timescale 1ns / 100ps

module tb_zip_stored_archive_validator_core;
    import zsav_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        stream_last;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        archive_ok;
    logic [3:0]  error_code;
    logic [15:0] entries_seen;
    logic [47:0] bytes_seen;
    logic        times_uniform;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [47:0] cfg_data;
    int          fail_count;
    int          verdicts_pending;
    int          verdicts_checked;
    int          clean_verdicts;

    int          send_idle_pct;
    int          stall_pct;
    int          idle_cycles = 0;
    int          bytes_sent;
    int          archives_sent;
    logic [7:0]  arch_q[$];
    logic [15:0] arch_tm;
    logic [15:0] arch_dt;

    zip_stored_archive_validator_core uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .stream_last(stream_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .archive_ok(archive_ok), .error_code(error_code),
        .entries_seen(entries_seen), .bytes_seen(bytes_seen),
        .times_uniform(times_uniform),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    zip_stored_archive_validator_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .stream_last(stream_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .archive_ok(archive_ok), .error_code(error_code),
        .entries_seen(entries_seen), .bytes_seen(bytes_seen),
        .times_uniform(times_uniform),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .verdicts_pending(verdicts_pending),
        .verdicts_checked(verdicts_checked), .clean_verdicts(clean_verdicts)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: cycles in which no request moves on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("zip_stored_archive_validator_core test failed");
            $finish;
        end
    end

    task automatic put16(input logic [15:0] v);
        arch_q = {arch_q, v[7:0], v[15:8]};
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endtask

    // One local entry; the defaults describe a clean stored entry.
    task automatic add_entry(input string name, input int dlen, input int xlen = 0,
                             input logic [15:0] flags = 0, input logic [15:0] method = 0,
                             input logic size_skew = 0, input logic crc_skew = 0);
        logic [7:0]  data [$];
        logic [31:0] c;
        c = 32'hffffffff;
        for (int i = 0; i < dlen; i++)
        begin
            data = {data, 8'($urandom_range(255))};
            c = c ^ {24'd0, data[i]};
            for (int k = 0; k < 8; k++)
                c = (c >> 1) ^ (32'hedb88320 & {32{c[0]}});
        end
        put32(SIG_LOCAL);
        put16(16'($urandom_range(65535)));
        put16(flags);
        put16(method);
        put16(arch_tm);
        put16(arch_dt);
        put32(~c ^ {31'd0, crc_skew});
        put32(32'(dlen));
        put32(32'(dlen + size_skew));
        put16(16'(name.len()));
        put16(16'(xlen));
        for (int i = 0; i < name.len(); i++)
            arch_q = {arch_q, 8'(name[i])};
        for (int i = 0; i < xlen; i++)
            arch_q = {arch_q, 8'($urandom_range(255))};
        foreach (data[i])
            arch_q = {arch_q, data[i]};
    endtask

    task automatic valid_stamp();
        arch_tm = {5'($urandom_range(23)), 6'($urandom_range(59)), 5'($urandom_range(29))};
        arch_dt = {7'($urandom_range(127)), 4'($urandom_range(12, 1)),
                   5'($urandom_range(31, 1))};
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        stream_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the built archive with stream_last on its final byte, then clears it.
    task automatic send_archive();
        foreach (arch_q[i])
            send_byte(arch_q[i], i == arch_q.size() - 1);
        in_valid <= 1'b0;
        arch_q.delete();
        archives_sent++;
    endtask

    task automatic write_cap(input logic [47:0] v);
        wait (verdicts_pending == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_name(input string name);
        valid_stamp();
        add_entry(name, 2);
        put32(SIG_END);
        send_archive();
    endtask

    task automatic random_archive();
        string       name;
        string       pool;
        int          n_entries;
        int          r;
        logic        same_stamp;
        n_entries  = $urandom_range(2, 1);
        same_stamp = 1'($urandom_range(1));
        valid_stamp();
        for (int e = 0; e < n_entries; e++)
        begin
            if (!same_stamp)
                valid_stamp();
            if ($urandom_range(99) < 5)
            begin
                arch_tm = 16'($urandom_range(65535));
                arch_dt = 16'($urandom_range(65535));
            end
            name = "";
            for (int i = $urandom_range(4, 1); i > 0; i--)
            begin
                pool = ($urandom_range(99) < 10) ? "/\\:." : "abz09._-";
                name = {name, pool.substr(0, 0)};
                name[name.len() - 1] = pool[$urandom_range(pool.len() - 1)];
            end
            r = $urandom_range(99);
            add_entry(name, $urandom_range(8), ($urandom_range(9) == 0) ? $urandom_range(3) : 0,
                      (r == 0) ? 16'h0008 : 16'($urandom_range(65535)) & 16'hfff7,
                      (r == 1) ? 16'($urandom_range(65535, 1)) : 16'd0,
                      r == 2, r == 3);
        end
        r = $urandom_range(99);
        if (r < 45)
            put32(SIG_END);
        else if (r < 80)
            put32(SIG_CENTRAL);
        else if (r < 88)
            put32($urandom);
        else
            repeat ($urandom_range(arch_q.size() - 1)) void'(arch_q.pop_back());
        repeat ($urandom_range(3))
            arch_q = {arch_q, 8'($urandom_range(255))};
        send_archive();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'd0;
        stream_last   = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 48'd0;
        send_idle_pct = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        archives_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed archives under the reset cap.
        valid_stamp();
        add_entry("a", 3);
        add_entry("d/e.txt", 0, 2);
        put32(SIG_END);
        send_archive();
        put32(SIG_CENTRAL);
        send_archive();
        put32(32'h12345678);
        send_archive();
        valid_stamp();
        add_entry("x", 1, 0, 16'hfff8);
        send_archive();
        add_entry("x", 1, 0, 16'h0000, 16'hffff);
        send_archive();
        add_entry("x", 1, 0, 16'h0000, 16'h0000, 1'b1);
        send_archive();
        add_entry("x", 4, 0, 16'h0000, 16'h0000, 1'b0, 1'b1);
        send_archive();
        directed_name("");
        directed_name("/a");
        directed_name("a\\b");
        directed_name("a:b");
        directed_name("a//b");
        directed_name("./a");
        directed_name("../a");
        directed_name("a/..");
        directed_name("...");
        arch_tm = 16'hffff;
        arch_dt = 16'h0000;
        add_entry("t", 1);
        put32(SIG_END);
        send_archive();
        arch_tm = 16'h0000;
        arch_dt = 16'h0021;
        add_entry("t", 0);
        add_entry("u", 0);
        arch_q = {arch_q, 8'h50};
        send_archive();

        // A small cap: entries of zero and four bytes fit, one more byte does not.
        write_cap(48'd4);
        valid_stamp();
        add_entry("z", 0);
        add_entry("y", 4);
        add_entry("w", 1);
        put32(SIG_END);
        send_archive();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  write_cap(CAP_RESET); end
                1: begin send_idle_pct = 86; stall_pct = 0;  write_cap(48'd0); end
                2: begin send_idle_pct = 0;  stall_pct = 86; write_cap($urandom_range(30)); end
                default: begin send_idle_pct = 29; stall_pct = 29; write_cap({$urandom, 16'hffff}); end
            endcase
            for (int a = 0; a < 2; a++)
            begin
                random_archive();
                if (a == 0)
                    wait (verdicts_pending == 0);
            end
        end

        wait (verdicts_pending == 0);
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes in %0d archives under five size caps and four idle patterns.",
                 bytes_sent, archives_sent);
        $display("Checked %0d verdicts, %0d of them clean.", verdicts_checked, clean_verdicts);
        if (fail_count == 0)
            $display("zip_stored_archive_validator_core test passed");
        else
            $display("zip_stored_archive_validator_core test failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/zsav_pkg.sv
hdl/zip_stored_archive_validator_core.sv
test/zip_stored_archive_validator_checker.sv
test/tb_zip_stored_archive_validator_core.sv
